FILE: rtl/core/gsa_pkg.sv
// gsa_pkg: types, sizes and codes shared by the generational slot allocator
// used by generational_slot_allocator; depends on nothing
package gsa_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int GEN_BITS   = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int DEPTH_W    = $clog2(SLOT_COUNT + 1);

    // fixed widths of the request and response fields
    localparam int OP_W     = 2;
    localparam int IDX_W    = 10;
    localparam int HGEN_W   = 16;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 11;

    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STALE   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  handle_index;
        logic [HGEN_W-1:0] handle_generation;
    } t_in_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot_number;
        logic [HGEN_W-1:0]   slot_generation;
        logic [LIVE_W-1:0]   live_count;
        logic                was_dirty;
    } t_out_rsp;

    // free stack entry carries the slot's current generation along with it
    typedef struct packed {
        logic [GEN_BITS-1:0] gen;
        logic [SLOT_W-1:0]   slot;
    } t_stack_ent;

    typedef struct packed {
        logic                active;
        logic [GEN_BITS-1:0] gen;
    } t_slot_ent;

endpackage

FILE: rtl/core/gsa_ram.sv
// gsa_ram: one write port, one registered read port, write-through on collision
// generic memory used for the free stack and the slot table; no dependencies
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic [WIDTH-1:0] r_byp_data;
    logic             r_byp;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata    <= r_mem[i_raddr];
            r_byp_data <= i_wdata;
        end
    end

    // a read that hits the address being written returns the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_re) begin
            r_byp <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_byp ? r_byp_data : r_rdata;

endmodule

FILE: rtl/core/generational_slot_allocator.sv
// generational slot allocator: free stack, slot table, live count, dirty flag
// response registered when the accepted request executes; one request per cycle unless stalled
// memory reads issue at accept; the update runs when the request executes, limited by
// the single write port of each memory, with write-through for back-to-back use
// after reset a clearing pass fills both memories; requests stall
// Depends on gsa_pkg and gsa_ram
module generational_slot_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  gsa_pkg::t_in_req  i_in_req,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output gsa_pkg::t_out_rsp o_out_rsp,
    input  logic              i_out_stall
);

    logic                             r_clearing;
    logic [gsa_pkg::SLOT_W-1:0]       r_clr_cnt;
    logic                             r_s1_valid;
    gsa_pkg::t_in_req                 r_s1_req;
    logic                             r_out_valid;
    gsa_pkg::t_out_rsp                r_out_rsp;
    logic [gsa_pkg::DEPTH_W-1:0]      r_depth;
    logic [gsa_pkg::DEPTH_W-1:0]      r_live;
    logic                             r_dirty;

    logic [gsa_pkg::DEPTH_W-1:0]      n_depth;
    logic [gsa_pkg::DEPTH_W-1:0]      n_live;
    logic                             n_dirty;
    gsa_pkg::t_out_rsp                n_rsp;

    logic                             exec;
    logic                             accept;
    logic [gsa_pkg::STATUS_W-1:0]     hs_status;
    logic [gsa_pkg::GEN_BITS-1:0]     gen_bump;

    gsa_pkg::t_stack_ent              st_top;
    gsa_pkg::t_slot_ent               sl_rd;

    logic                             ex_st_we;
    logic [gsa_pkg::SLOT_W-1:0]       ex_st_waddr;
    gsa_pkg::t_stack_ent              ex_st_wdata;
    logic                             ex_sl_we;
    logic [gsa_pkg::SLOT_W-1:0]       ex_sl_waddr;
    gsa_pkg::t_slot_ent               ex_sl_wdata;

    logic                             st_we;
    logic [gsa_pkg::SLOT_W-1:0]       st_waddr;
    gsa_pkg::t_stack_ent              st_wdata;
    logic                             sl_we;
    logic [gsa_pkg::SLOT_W-1:0]       sl_waddr;
    gsa_pkg::t_slot_ent               sl_wdata;
    logic [gsa_pkg::DEPTH_W-1:0]      st_raddr_full;

    assign exec       = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clearing || (r_s1_valid && !exec);
    assign accept     = i_in_valid && !o_in_stall;

    // handle validation against the slot table
    always_comb begin
        if (32'(r_s1_req.handle_index) >= gsa_pkg::SLOT_COUNT) begin
            hs_status = gsa_pkg::ST_RANGE;
        end else if (!sl_rd.active ||
                     sl_rd.gen != gsa_pkg::GEN_BITS'(r_s1_req.handle_generation)) begin
            hs_status = gsa_pkg::ST_STALE;
        end else begin
            hs_status = gsa_pkg::ST_OK;
        end
    end

    assign gen_bump = sl_rd.gen + gsa_pkg::GEN_BITS'(1);

    always_comb begin
        n_depth     = r_depth;
        n_live      = r_live;
        n_dirty     = r_dirty;
        ex_st_we    = 1'b0;
        ex_st_waddr = r_depth[gsa_pkg::SLOT_W-1:0];
        ex_st_wdata = '{gen: gen_bump, slot: gsa_pkg::SLOT_W'(r_s1_req.handle_index)};
        ex_sl_we    = 1'b0;
        ex_sl_waddr = gsa_pkg::SLOT_W'(r_s1_req.handle_index);
        ex_sl_wdata = '{active: 1'b0, gen: gen_bump};
        n_rsp.status          = gsa_pkg::ST_OK;
        n_rsp.slot_number     = r_s1_req.handle_index;
        n_rsp.slot_generation = '0;
        n_rsp.was_dirty       = 1'b0;
        case (r_s1_req.op)
            gsa_pkg::OP_CREATE: begin
                if (r_depth == '0) begin
                    n_rsp.status      = gsa_pkg::ST_NO_SLOT;
                    n_rsp.slot_number = '0;
                end else begin
                    n_depth     = r_depth - gsa_pkg::DEPTH_W'(1);
                    n_live      = r_live + gsa_pkg::DEPTH_W'(1);
                    n_dirty     = 1'b1;
                    ex_sl_we    = 1'b1;
                    ex_sl_waddr = st_top.slot;
                    ex_sl_wdata = '{active: 1'b1, gen: st_top.gen};
                    n_rsp.slot_number     = gsa_pkg::IDX_W'(st_top.slot);
                    n_rsp.slot_generation = gsa_pkg::HGEN_W'(st_top.gen);
                end
            end
            gsa_pkg::OP_DESTROY: begin
                n_rsp.status = hs_status;
                if (hs_status == gsa_pkg::ST_OK) begin
                    n_dirty  = 1'b1;
                    ex_sl_we = 1'b1;
                    if (32'(r_depth) < gsa_pkg::SLOT_COUNT) begin
                        ex_st_we = 1'b1;
                        n_depth  = r_depth + gsa_pkg::DEPTH_W'(1);
                    end
                    if (r_live != '0) begin
                        n_live = r_live - gsa_pkg::DEPTH_W'(1);
                    end
                end
            end
            gsa_pkg::OP_CHECK: begin
                n_rsp.status = hs_status;
            end
            default: begin
                n_rsp.was_dirty = r_dirty;
                n_dirty         = 1'b0;
            end
        endcase
        n_rsp.live_count = gsa_pkg::LIVE_W'(n_live);
    end

    // memory write ports: clearing pass owns them until it finishes
    always_comb begin
        if (r_clearing) begin
            st_we    = 1'b1;
            st_waddr = r_clr_cnt;
            st_wdata = '{gen:  gsa_pkg::GEN_BITS'(1),
                         slot: gsa_pkg::SLOT_W'(gsa_pkg::SLOT_COUNT - 1) - r_clr_cnt};
            sl_we    = 1'b1;
            sl_waddr = r_clr_cnt;
            sl_wdata = '{active: 1'b0, gen: gsa_pkg::GEN_BITS'(1)};
        end else begin
            st_we    = exec && ex_st_we;
            st_waddr = ex_st_waddr;
            st_wdata = ex_st_wdata;
            sl_we    = exec && ex_sl_we;
            sl_waddr = ex_sl_waddr;
            sl_wdata = ex_sl_wdata;
        end
    end

    // top of stack as it stands after this cycle's update
    assign st_raddr_full = (exec ? n_depth : r_depth) - gsa_pkg::DEPTH_W'(1);

    gsa_ram #(
        .WIDTH ($bits(gsa_pkg::t_stack_ent)),
        .DEPTH (gsa_pkg::SLOT_COUNT)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (accept),
        .i_raddr (st_raddr_full[gsa_pkg::SLOT_W-1:0]),
        .o_rdata (st_top)
    );

    gsa_ram #(
        .WIDTH ($bits(gsa_pkg::t_slot_ent)),
        .DEPTH (gsa_pkg::SLOT_COUNT)
    ) u_slot_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (sl_we),
        .i_waddr (sl_waddr),
        .i_wdata (sl_wdata),
        .i_re    (accept),
        .i_raddr (gsa_pkg::SLOT_W'(i_in_req.handle_index)),
        .o_rdata (sl_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_cnt   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_depth     <= gsa_pkg::DEPTH_W'(gsa_pkg::SLOT_COUNT);
            r_live      <= '0;
            r_dirty     <= 1'b1;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + gsa_pkg::SLOT_W'(1);
                if (r_clr_cnt == gsa_pkg::SLOT_W'(gsa_pkg::SLOT_COUNT - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (exec) begin
                r_s1_valid <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
                r_depth     <= n_depth;
                r_live      <= n_live;
                r_dirty     <= n_dirty;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req <= i_in_req;
        end
        if (exec) begin
            r_out_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

`ifndef SYNTHESIS
    a_count_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) + 32'(r_depth) == gsa_pkg::SLOT_COUNT)
        else $error("live count and free depth out of balance");

    a_create_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && r_s1_req.op == gsa_pkg::OP_CREATE && r_depth != '0
        |=> r_out_rsp.live_count == gsa_pkg::LIVE_W'($past(r_live) + gsa_pkg::DEPTH_W'(1)))
        else $error("create did not raise the live count");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && r_s1_req.op == gsa_pkg::OP_FLUSH |=> !r_dirty)
        else $error("flush left the dirty flag set");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> !r_s1_valid && r_live == '0)
        else $error("requests taken during the clearing pass");
`endif

endmodule
